FILE: hw/rtl/b64e_pkg.sv
// package for the line-wrapped base64 encoder
// holds the job type, character codes and the symbol table; no dependencies
package b64e_pkg;

  localparam int unsigned LINE_CHARS = 76;

  localparam logic [6:0] CHAR_CR  = 7'h0D;
  localparam logic [6:0] CHAR_LF  = 7'h0A;
  localparam logic [6:0] CHAR_PAD = 7'h3D;

  localparam int unsigned QUEUE_DEPTH = 2;

  // one unit of back-end work: four symbols, optional line break, end flag
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic            crlf;
    logic            last;
  } job_t;

  // standard alphabet A-Z a-z 0-9 + /
  function automatic logic [6:0] sym(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'h61 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 7'h30 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      r = 7'h2B;
    end else begin
      r = 7'h2F;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/b64e_front.sv
// front end: takes bytes, gathers groups, tracks line length, builds jobs
// depends on b64e_pkg
module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              push_o,
  output b64e_pkg::job_t    job_o
);
  import b64e_pkg::*;

  logic [1:0]       pos_q, pos_d, pos;
  logic [1:0][7:0]  held_q, held_d;
  logic [6:0]       line_q, line_d, line_sum;

  always_comb begin
    pos      = (pos_q == 2'd3) ? 2'd0 : pos_q;
    pos_d    = pos_q;
    held_d   = held_q;
    line_d   = line_q;
    line_sum = line_q + 7'd4;
    push_o   = 1'b0;
    job_o    = '0;
    job_o.last = last_byte_i;
    if (accept_i) begin
      if (pos == 2'd2) begin
        push_o        = 1'b1;
        job_o.chars[0] = sym(held_q[0][7:2]);
        job_o.chars[1] = sym({held_q[0][1:0], held_q[1][7:4]});
        job_o.chars[2] = sym({held_q[1][3:0], data_byte_i[7:6]});
        job_o.chars[3] = sym(data_byte_i[5:0]);
        job_o.crlf     = (line_sum >= 7'(LINE_CHARS));
        line_d         = job_o.crlf ? 7'd0 : line_sum;
        pos_d          = 2'd0;
        held_d         = '0;
      end else if (last_byte_i) begin
        push_o = 1'b1;
        if (pos == 2'd0) begin
          job_o.chars[0] = sym(data_byte_i[7:2]);
          job_o.chars[1] = sym({data_byte_i[1:0], 4'd0});
          job_o.chars[2] = CHAR_PAD;
          job_o.chars[3] = CHAR_PAD;
        end else begin
          job_o.chars[0] = sym(held_q[0][7:2]);
          job_o.chars[1] = sym({held_q[0][1:0], data_byte_i[7:4]});
          job_o.chars[2] = sym({data_byte_i[3:0], 2'd0});
          job_o.chars[3] = CHAR_PAD;
        end
      end else begin
        held_d[pos[0]] = data_byte_i;
        pos_d          = pos + 2'd1;
      end
      // message end returns everything to start
      if (last_byte_i) begin
        pos_d  = 2'd0;
        held_d = '0;
        line_d = 7'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      held_q <= '0;
      line_q <= 7'd0;
    end else begin
      pos_q  <= pos_d;
      held_q <= held_d;
      line_q <= line_d;
    end
  end

endmodule

FILE: hw/rtl/b64e_queue.sv
// two-entry job queue between front and back end
// depends on b64e_pkg
module b64e_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64e_pkg::job_t    job_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output b64e_pkg::job_t    head_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  job_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/b64e_back.sv
// back end: walks the head job one character a cycle, while the output is not
// stalled, into the output register; depends on b64e_pkg
module b64e_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  b64e_pkg::job_t    head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [6:0]        out_char_o,
  output logic              out_last_o
);
  import b64e_pkg::*;

  logic [2:0] idx_q, idx_d, end_idx;
  logic       load, valid_q, valid_d;
  logic [6:0] char_q, char_d;
  logic       last_q, last_d;
  logic       at_end;

  assign end_idx = head_i.crlf ? 3'd5 : 3'd3;
  assign at_end  = (idx_q == end_idx);
  assign load    = !empty_i && (!valid_q || out_ready_i);
  assign pop_o   = load && at_end;

  always_comb begin
    case (idx_q)
      3'd4:    char_d = CHAR_CR;
      3'd5:    char_d = CHAR_LF;
      default: char_d = head_i.chars[idx_q[1:0]];
    endcase
    last_d  = at_end && head_i.last;
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = at_end ? 3'd0 : idx_q + 3'd1;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

FILE: hw/rtl/base64_line_wrapped_encoder_unit.sv
// channel  | direction | handshake               | payload
// input    | in        | in_valid_i / in_ready_o   | data_byte_i, last_byte_i
// output   | out       | out_valid_o / out_ready_i | out_char_o, out_last_o
//
// one character leaves per cycle while out_ready_i is high; a full group is
// four characters, six with a line break, so three bytes give four characters
// plus breaks, walked by the back-end character counter over the head job
// bytes are taken while the two-entry job queue has room; a stalled output
// fills the queue and then holds in_ready_o low
// reset is asynchronous, active low, and clears group, line and queue state
module base64_line_wrapped_encoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       out_last_o
);
  import b64e_pkg::*;

  job_t job, head;
  logic push, pop, full, empty, accept;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .job_o       (job)
  );

  b64e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

endmodule

FILE: hw/rtl/b64e_checker.sv
// port-level checks for the encoder top level, attached by bind
// depends on b64e_pkg
module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] out_char_o,
  input logic       out_last_o
);
  import b64e_pkg::*;

  // an offered item stays offered until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input item withdrawn before it was taken");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) && $stable(out_last_o))
    else $error("output changed while stalled");

  // CR is always followed at once by LF
  a_cr_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_char_o == CHAR_CR
    |=> out_valid_o && out_char_o == CHAR_LF)
    else $error("CR not followed by LF");

  // a non-final pad is followed by the final pad
  a_pad_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_char_o == CHAR_PAD && !out_last_o
    |=> out_valid_o && out_char_o == CHAR_PAD && out_last_o)
    else $error("first pad not followed by final pad");

  // CR never ends a message
  a_cr_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_char_o == CHAR_CR |-> !out_last_o)
    else $error("message ended on CR");

endmodule

bind base64_line_wrapped_encoder_unit b64e_checker u_b64e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_char_o  (out_char_o),
  .out_last_o  (out_last_o)
);

FILE: dv/base64_line_wrapped_encoder_unit_tb.sv
// testbench for base64_line_wrapped_encoder_unit: drives byte messages, predicts the
// encoded text with line breaks and padding, and checks every output character
// depends on b64e_pkg for the line length and the CR, LF and pad codes
module base64_line_wrapped_encoder_unit_tb;
  import b64e_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned HOLD_CYCLES    = 220;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [6:0] ch;
    logic       is_last;
  } enc_char_t;

  typedef logic [7:0] byte_list_t[$];

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [6:0] out_char_o;
  logic       out_last_o;

  base64_line_wrapped_encoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_char_o (out_char_o),
    .out_last_o (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  string b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // encoder state mirrored by the predictor
  logic [7:0] held_q [2];
  logic [1:0] grp_pos;
  logic [6:0] line_cnt;

  enc_char_t pending_chars[$];

  int unsigned error_cnt    = 0;
  int unsigned bytes_sent   = 0;
  int unsigned msgs_sent    = 0;
  int unsigned chars_seen   = 0;
  int unsigned breaks_seen  = 0;
  int unsigned burst_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned idle_cycles  = 0;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    return 7'(b64_alphabet[v]);
  endfunction

  task automatic clear_encoder_state();
    held_q[0] = 8'h00;
    held_q[1] = 8'h00;
    grp_pos   = 2'd0;
    line_cnt  = 7'd0;
  endtask

  task automatic push_char(input logic [6:0] ch);
    enc_char_t c;
    c.ch      = ch;
    c.is_last = 1'b0;
    pending_chars.push_back(c);
  endtask

  // works out the characters caused by one accepted byte
  task automatic encode_byte(input logic [7:0] b, input logic is_last);
    int unsigned start_size;
    logic [7:0]  b0;
    logic [7:0]  b1;
    start_size = pending_chars.size();
    b0 = held_q[0];
    b1 = held_q[1];
    if (grp_pos == 2'd2) begin
      push_char(b64_char(b0[7:2]));
      push_char(b64_char({b0[1:0], b1[7:4]}));
      push_char(b64_char({b1[3:0], b[7:6]}));
      push_char(b64_char(b[5:0]));
      line_cnt = line_cnt + 7'd4;
      if (line_cnt >= LINE_CHARS) begin
        push_char(CHAR_CR);
        push_char(CHAR_LF);
        line_cnt = 7'd0;
      end
      grp_pos   = 2'd0;
      held_q[0] = 8'h00;
      held_q[1] = 8'h00;
    end else if (is_last) begin
      if (grp_pos == 2'd0) begin
        push_char(b64_char(b[7:2]));
        push_char(b64_char({b[1:0], 4'h0}));
        push_char(CHAR_PAD);
        push_char(CHAR_PAD);
      end else begin
        push_char(b64_char(b0[7:2]));
        push_char(b64_char({b0[1:0], b[7:4]}));
        push_char(b64_char({b[3:0], 2'b00}));
        push_char(CHAR_PAD);
      end
    end else begin
      held_q[grp_pos[0]] = b;
      grp_pos = grp_pos + 2'd1;
    end
    if (is_last) begin
      if (pending_chars.size() > start_size) begin
        pending_chars[pending_chars.size() - 1].is_last = 1'b1;
      end
      clear_encoder_state();
      msgs_sent++;
    end
  endtask

  // offers one byte, holds it until taken, then maybe idles between bursts
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    encode_byte(b, is_last);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      // some bursts are long stretches with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_message(input byte_list_t bytes);
    foreach (bytes[i]) begin
      send_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  task automatic send_random_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'h00, 8'hFF});
    send_message('{8'hFF, 8'h00});
    // all four symbols are the plus sign
    send_message('{8'hFB, 8'hEF, 8'hBE});
    // 0xFF 0xFF 0xFF gives four slashes, then a one-byte tail
    send_message('{8'hFF, 8'hFF, 8'hFF, 8'h00});
    send_message('{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF});
    send_message('{8'h80, 8'h01});
  endtask

  task automatic test_line_wrap();
    int unsigned pick;
    int unsigned len;
    // exactly one full line, so the break lands on the final group
    send_random_message(57);
    while (bytes_sent < 190) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: len = $urandom_range(1, 12);
        3, 4:    len = $urandom_range(55, 60);
        5:       len = 114;
        6:       len = 3 * $urandom_range(1, 8);
        7:       len = 3 * $urandom_range(1, 8) + 1;
        default: len = $urandom_range(13, 40);
      endcase
      // keep the total near the planned byte count
      if (len > 190 - bytes_sent) begin
        len = 190 - bytes_sent;
      end
      send_random_message(len);
    end
  endtask

  task automatic test_output_stall();
    hold_left = HOLD_CYCLES;
    repeat (4) send_random_message($urandom_range(6, 14));
  endtask

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned act_v);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS) begin
      $display("mismatch on %s at char %0d: expected 0x%02h, got 0x%02h",
               what, chars_seen, exp_v, act_v);
    end
  endtask

  // character checker
  always @(posedge clk_i) begin
    enc_char_t exp_c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        error_cnt++;
        if (error_cnt <= MAX_REPORTS) begin
          $display("unexpected char 0x%02h (last=%0b) with nothing pending",
                   out_char_o, out_last_o);
        end
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_char_o !== exp_c.ch) report_mismatch("out_char", exp_c.ch, out_char_o);
        if (out_last_o !== exp_c.is_last) begin
          report_mismatch("out_last", exp_c.is_last, out_last_o);
        end
        if (exp_c.ch == CHAR_LF) breaks_seen++;
      end
      chars_seen++;
    end
  end

  // receiver: switches between stall patterns, with one long hold-off on request
  always @(negedge clk_i) begin
    logic [1:0]  rx_mode;
    int unsigned mode_left;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = 2'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        2'd0:    out_ready_i <= 1'b1;
        2'd1:    out_ready_i <= 1'($urandom_range(0, 1));
        2'd2:    out_ready_i <= ($urandom_range(0, 4) != 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    clear_encoder_state();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_line_wrap();
    test_output_stall();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_chars.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d bytes in %0d messages, %0d chars checked, %0d line breaks",
             bytes_sent, msgs_sent, chars_seen, breaks_seen);
    $display("included padded tails of one and two bytes and a long output hold-off");
    if (error_cnt == 0 && pending_chars.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d errors, %0d chars never seen", error_cnt, pending_chars.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: base64_line_wrapped_encoder_unit.f
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_line_wrapped_encoder_unit.sv
hw/rtl/b64e_checker.sv
dv/base64_line_wrapped_encoder_unit_tb.sv
